[rtl/core/raw_huffman_dpcm_pixel_decoder_defines.svh]
// Assertion macros used by the checker module.
`ifndef RAW_HUFFMAN_DPCM_PIXEL_DECODER_DEFINES_SVH
`define RAW_HUFFMAN_DPCM_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RHD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RHD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rhd_pkg.sv]
package rhd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 16'd2;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 16'd1;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_PIXEL     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_CODE  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EARLY_END = 2'd2;

    // Bit buffer: at most 21 leftover bits plus one new byte
    localparam int BUF_W  = 29;
    localparam int HELD_W = $clog2(BUF_W + 1);

    // Symbols decoded from one byte at most
    localparam int SYMS_PER_BYTE = 3;

    // Default depth of the command queue between front and back
    localparam int RHD_QUEUE_DEPTH = 4;

    // Canonical Huffman table, lengths 1 to 10
    localparam int HUFF_MAX_LEN   = 10;
    localparam int HUFF_MAX_EXTRA = 12;
    localparam int HUFF_NSYM      = 13;

    localparam logic [HUFF_MAX_LEN-1:0] HUFF_FIRST [HUFF_MAX_LEN] = '{
        10'd0, 10'd0, 10'd4, 10'd14, 10'd30, 10'd62, 10'd126, 10'd254, 10'd510, 10'd1022
    };
    localparam logic [1:0] HUFF_COUNT [HUFF_MAX_LEN] = '{
        2'd0, 2'd2, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2
    };
    localparam logic [3:0] HUFF_INDEX [HUFF_MAX_LEN] = '{
        4'd0, 4'd0, 4'd2, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11
    };
    localparam logic [3:0] HUFF_SYMBOL [HUFF_NSYM] = '{
        4'd3, 4'd4, 4'd2, 4'd5, 4'd1, 4'd6, 4'd0, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12
    };

    typedef struct packed {
        logic [3:0] len;
        logic [3:0] sym;
    } t_huff;

    typedef enum logic {
        CMD_PIXEL,
        CMD_EARLY_END
    } t_cmd_kind;

    // One queued command from the front to the back
    typedef struct packed {
        t_cmd_kind          kind;
        logic [PIXEL_W-1:0] diff;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
    } t_cfg;

    // Code length and symbol of the code at the top of a 10-bit window.
    // Shortest matching length wins; the table is complete within 10 bits.
    function automatic t_huff huff_lookup(input logic [HUFF_MAX_LEN-1:0] top);
        t_huff                   res;
        logic [HUFF_MAX_LEN-1:0] code;
        logic [HUFF_MAX_LEN-1:0] off;
        logic [3:0]              pos;
        res.len = 4'(HUFF_MAX_LEN);
        res.sym = 4'd0;
        for (int k = HUFF_MAX_LEN; k >= 1; k--) begin
            code = top >> (HUFF_MAX_LEN - k);
            off  = code - HUFF_FIRST[k-1];
            pos  = HUFF_INDEX[k-1] + off[3:0];
            if (off < HUFF_MAX_LEN'(HUFF_COUNT[k-1])) begin
                res.len = 4'(k);
                res.sym = HUFF_SYMBOL[pos];
            end
        end
        return res;
    endfunction

endpackage

[rtl/core/rhd_channels.sv]
// Compressed byte channel
interface rhd_byte_if;
    import rhd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              last_byte;
    modport source (output valid, output stream_byte, output last_byte, input ready);
    modport sink   (input valid, input stream_byte, input last_byte, output ready);
endinterface

// Decoded pixel / status channel
interface rhd_pixel_if;
    import rhd_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;
    logic [STAT_W-1:0]  status;
    logic               image_done;
    logic               run_last;
    modport source (output valid, output pixel_value, output status, output image_done,
                    output run_last, input ready);
    modport sink   (input valid, input pixel_value, input status, input image_done,
                    input run_last, output ready);
endinterface

// Configuration write channel
interface rhd_cfg_if;
    import rhd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/raw_huffman_dpcm_pixel_decoder.sv]
// Front: a byte is taken only while the front is idle, once the previous byte is
// fully decoded; each byte yields 0 to 3 symbols, decoded one symbol a cycle
// while the queue accepts them. Back: one queued command becomes one result per
// cycle while results are taken; once halted it drops the commands instead.
// Reset: i_rst_n low at a clock edge clears the bit buffer, predictors, position,
// halt flag and queue, and loads image_width 2 and image_height 1; no clearing pass.
module raw_huffman_dpcm_pixel_decoder #(
    parameter int QUEUE_DEPTH = rhd_pkg::RHD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhd_byte_if.sink    i_byte,
    rhd_pixel_if.source o_pixel,
    rhd_cfg_if.sink     i_cfg
);
    import rhd_pkg::*;

    t_cfg r_cfg;
    logic push_valid;
    t_cmd push_cmd;
    logic push_ready;
    logic pop_valid;
    t_cmd pop_cmd;
    logic pop_ready;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_IMAGE_WIDTH;
            r_cfg.height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_cfg.width  <= i_cfg.data;
                CFG_IMAGE_HEIGHT: r_cfg.height <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    rhd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    rhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    rhd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop_ready (pop_ready),
        .o_pixel     (o_pixel)
    );

endmodule

[rtl/core/rhd_front.sv]
module rhd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rhd_byte_if.sink      i_byte,
    output logic          o_push_valid,
    output rhd_pkg::t_cmd o_push_cmd,
    input  logic          i_push_ready
);
    import rhd_pkg::*;

    localparam int CNT_W = $clog2(SYMS_PER_BYTE + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EARLY
    } t_state;

    t_state             r_state;
    logic [BUF_W-1:0]   r_buf;
    logic [HELD_W-1:0]  r_held;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_last;
    logic               r_pend_valid;
    t_cmd               r_pend;

    logic [BUF_W-1:0]          aligned;
    logic [BUF_W-1:0]          rest;
    t_huff                     hl;
    logic [HUFF_MAX_EXTRA-1:0] ext;
    logic [HUFF_MAX_EXTRA-1:0] extra12;
    logic [PIXEL_W-1:0]        extra16;
    logic [PIXEL_W-1:0]        mask16;
    logic                      sign_bit;
    logic [PIXEL_W-1:0]        diff;
    logic [HELD_W-1:0]         total;
    logic [HELD_W-1:0]         held_next;
    logic [BUF_W-1:0]          buf_next;
    logic                      dec_ok;
    logic                      take_sym;

    // Decode the code at the head of the buffer
    always_comb begin
        aligned   = r_buf << (HELD_W'(BUF_W) - r_held);
        hl        = huff_lookup(aligned[BUF_W-1 -: HUFF_MAX_LEN]);
        rest      = aligned << hl.len;
        ext       = rest[BUF_W-1 -: HUFF_MAX_EXTRA];
        extra12   = ext >> (4'(HUFF_MAX_EXTRA) - hl.sym);
        extra16   = PIXEL_W'(extra12);
        mask16    = (PIXEL_W'(1) << hl.sym) - PIXEL_W'(1);
        // Leading extra bit clear means a negative difference
        sign_bit  = |(extra16 & (mask16 ^ (mask16 >> 1)));
        diff      = sign_bit ? extra16 : (extra16 - mask16);
        total     = HELD_W'(hl.len) + HELD_W'(hl.sym);
        held_next = r_held - total;
        buf_next  = r_buf & ~({BUF_W{1'b1}} << held_next);
        dec_ok    = (total <= r_held) && (r_cnt != CNT_W'(SYMS_PER_BYTE));
    end

    // Queue push: the pending symbol goes out once the next decode shows whether it ends the byte
    always_comb begin
        o_push_valid = 1'b0;
        o_push_cmd   = r_pend;
        take_sym     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_DECODE: begin
                if (dec_ok) begin
                    if (r_pend_valid) begin
                        o_push_valid    = 1'b1;
                        o_push_cmd.last = 1'b0;
                        take_sym        = i_push_ready;
                    end else begin
                        take_sym = 1'b1;
                    end
                end else if (r_pend_valid) begin
                    o_push_valid    = 1'b1;
                    o_push_cmd.last = !r_last;
                end
            end
            S_EARLY: begin
                o_push_valid    = 1'b1;
                o_push_cmd.kind = CMD_EARLY_END;
                o_push_cmd.diff = '0;
                o_push_cmd.last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign i_byte.ready = (r_state == S_IDLE);

    // Sequencer and bit buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_buf        <= '0;
            r_held       <= '0;
            r_cnt        <= '0;
            r_last       <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_byte.valid) begin
                        r_buf   <= {r_buf[BUF_W-BYTE_W-1:0], i_byte.stream_byte};
                        r_held  <= r_held + HELD_W'(BYTE_W);
                        r_cnt   <= '0;
                        r_last  <= i_byte.last_byte;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (take_sym) begin
                        r_buf        <= buf_next;
                        r_held       <= held_next;
                        r_cnt        <= r_cnt + CNT_W'(1);
                        r_pend_valid <= 1'b1;
                        r_pend.kind  <= CMD_PIXEL;
                        r_pend.diff  <= diff;
                        r_pend.last  <= 1'b0;
                    end else if (!dec_ok && (!r_pend_valid || i_push_ready)) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= r_last ? S_EARLY : S_IDLE;
                    end
                end
                S_EARLY: begin
                    if (i_push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/rhd_queue.sv]
module rhd_queue #(
    parameter int DEPTH = rhd_pkg::RHD_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  rhd_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output rhd_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop_ready
);
    import rhd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/rhd_back.sv]
module rhd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rhd_pkg::t_cfg i_cfg,
    input  logic          i_pop_valid,
    input  rhd_pkg::t_cmd i_pop_cmd,
    output logic          o_pop_ready,
    rhd_pixel_if.source   o_pixel
);
    import rhd_pkg::*;

    localparam int POS_W = 16;

    logic [PIXEL_W-1:0] r_up   [4];
    logic [PIXEL_W-1:0] r_left [2];
    logic [POS_W-1:0]   r_col;
    logic [POS_W-1:0]   r_row;
    logic               r_halted;
    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_pix;
    logic [STAT_W-1:0]  r_status;
    logic               r_done;
    logic               r_run_last;

    logic               par;
    logic [1:0]         ui;
    logic               first_pair;
    logic [PIXEL_W-1:0] pred;
    logic [PIXEL_W-1:0] n_sum;
    logic [POS_W:0]     w_up;
    logic [POS_W:0]     weff;
    logic [POS_W:0]     heff;
    logic               row_end;
    logic               done;
    logic               load;

    // Prediction and position tests for the command at the queue head
    always_comb begin
        par        = r_col[0];
        ui         = {r_row[0], par};
        first_pair = (r_col[POS_W-1:1] == '0);
        pred       = first_pair ? r_up[ui] : r_left[par];
        n_sum      = pred + i_pop_cmd.diff;
        w_up       = {1'b0, i_cfg.width} + (POS_W+1)'(1);
        weff       = {w_up[POS_W:1], 1'b0};
        if (weff < (POS_W+1)'(2)) begin
            weff = (POS_W+1)'(2);
        end
        heff       = (i_cfg.height == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, i_cfg.height};
        row_end    = ({1'b0, r_col} + (POS_W+1)'(1)) >= weff;
        done       = row_end && (({1'b0, r_row} + (POS_W+1)'(1)) >= heff);
    end

    // Once halted, commands are drained and dropped
    assign o_pop_ready = r_halted || !r_out_valid || o_pixel.ready;
    assign load        = i_pop_valid && o_pop_ready && !r_halted;

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_value = r_pix;
    assign o_pixel.status      = r_status;
    assign o_pixel.image_done  = r_done;
    assign o_pixel.run_last    = r_run_last;

    // Predictors, position and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up        <= '{default: '0};
            r_left      <= '{default: '0};
            r_col       <= '0;
            r_row       <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pixel.ready) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
                unique case (i_pop_cmd.kind)
                    CMD_EARLY_END: begin
                        r_pix      <= '0;
                        r_status   <= STATUS_EARLY_END;
                        r_done     <= 1'b0;
                        r_run_last <= i_pop_cmd.last;
                        r_halted   <= 1'b1;
                    end
                    CMD_PIXEL: begin
                        if (first_pair) begin
                            r_up[ui] <= n_sum;
                        end
                        r_left[par] <= n_sum;
                        r_pix       <= n_sum;
                        r_status    <= STATUS_PIXEL;
                        r_done      <= done;
                        r_run_last  <= i_pop_cmd.last || done;
                        if (done) begin
                            r_halted <= 1'b1;
                        end else if (row_end) begin
                            r_col <= '0;
                            r_row <= r_row + POS_W'(1);
                        end else begin
                            r_col <= r_col + POS_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[rtl/core/rhd_checker.sv]
`include "raw_huffman_dpcm_pixel_decoder_defines.svh"

module rhd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [rhd_pkg::PIXEL_W-1:0] i_pixel_value,
    input logic [rhd_pkg::STAT_W-1:0]  i_status,
    input logic                       i_image_done,
    input logic                       i_run_last
);
    import rhd_pkg::*;

    logic r_halt_seen;
    logic out_take;

    assign out_take = i_out_valid && i_out_ready;

    // Remember a final result: image done or any error status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt_seen <= 1'b0;
        end else if (out_take && (i_image_done || (i_status != STATUS_PIXEL))) begin
            r_halt_seen <= 1'b1;
        end
    end

    // Stalled result holds
    `RHD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pixel_value) && $stable(i_status) && $stable(i_image_done) && $stable(i_run_last), "stalled result changed")

    // Nothing follows the final result
    `RHD_ASSERT_IMP(a_quiet_after_halt, i_clk, i_rst_n, r_halt_seen, !i_out_valid, "result after halt")

    // Only pixel or early-end status can come from a complete code table
    `RHD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, i_out_valid, (i_status == STATUS_PIXEL) || (i_status == STATUS_EARLY_END), "bad status code")

    // Image done is a pixel and closes its byte
    `RHD_ASSERT_IMP(a_done_shape, i_clk, i_rst_n, i_out_valid && i_image_done, (i_status == STATUS_PIXEL) && i_run_last, "image done on wrong result")

    // Early end carries no pixel and closes its byte
    `RHD_ASSERT_IMP(a_early_shape, i_clk, i_rst_n, i_out_valid && (i_status == STATUS_EARLY_END), i_run_last && (i_pixel_value == '0), "early end malformed")

endmodule

bind raw_huffman_dpcm_pixel_decoder rhd_checker u_rhd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_pixel.valid),
    .i_out_ready   (o_pixel.ready),
    .i_pixel_value (o_pixel.pixel_value),
    .i_status      (o_pixel.status),
    .i_image_done  (o_pixel.image_done),
    .i_run_last    (o_pixel.run_last)
);
